>>> rtl/b64_pkg.sv
// Shared types, constants and the sextet-to-ASCII lookup for the Base64 encoder.
package b64_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_URL_ALPHABET = 2'd0;
   localparam logic [1:0] CSR_LINE_BREAKS  = 2'd1;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   // Job queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   typedef struct packed {
      logic url_alphabet;
      logic insert_line_breaks;
   } cfg_type;

   // One group's worth of output: four characters, chars[0] goes out first,
   // then an optional newline.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic            newline;
      logic            last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
      logic [7:0] c;
      case (v) inside
         [6'd0:6'd25]:  c = 8'(v) + 8'd65;
         [6'd26:6'd51]: c = 8'(v) + 8'd71;
         [6'd52:6'd61]: c = 8'(v) - 8'd4;
         6'd62:         c = url ? 8'h2D : 8'h2B;
         default:       c = url ? 8'h5F : 8'h2F;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/b64_front.sv
// Front end: gathers input bytes into groups and turns each group into a job.
module b64_front #(
   parameter int LINE_BYTES = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  b64_pkg::cfg_type  cfg,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              last_byte,
   output logic              push,
   output b64_pkg::job_type  job
);
   import b64_pkg::*;

   logic [15:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_count_ff, group_count_in;
   logic [5:0]  line_cnt_ff, line_cnt_in;

   logic [23:0] g;
   logic [6:0]  cnt_next;
   logic        line_done;

   assign cnt_next  = {1'b0, line_cnt_ff} + 7'd3;
   assign line_done = cnt_next >= 7'(LINE_BYTES);

   always_comb begin
      group_bits_in  = group_bits_ff;
      group_count_in = group_count_ff;
      line_cnt_in    = line_cnt_ff;
      push           = 1'b0;
      job.chars      = '0;
      job.newline    = 1'b0;
      job.last       = last_byte;
      g              = {group_bits_ff, in_byte};
      if (group_count_ff == 2'd2) begin
         job.chars[0]   = sextet_char(g[23:18], cfg.url_alphabet);
         job.chars[1]   = sextet_char(g[17:12], cfg.url_alphabet);
         job.chars[2]   = sextet_char(g[11:6], cfg.url_alphabet);
         job.chars[3]   = sextet_char(g[5:0], cfg.url_alphabet);
         job.newline    = line_done && cfg.insert_line_breaks;
         push           = accept;
         group_bits_in  = '0;
         group_count_in = 2'd0;
         line_cnt_in    = line_done ? 6'd0 : cnt_next[5:0];
      end else begin
         group_bits_in  = {group_bits_ff[7:0], in_byte};
         group_count_in = group_count_ff + 2'd1;
         if (group_count_ff == 2'd0) begin
            g            = {in_byte, 16'h0000};
            job.chars[0] = sextet_char(g[23:18], cfg.url_alphabet);
            job.chars[1] = sextet_char(g[17:12], cfg.url_alphabet);
            job.chars[2] = CHAR_PAD;
            job.chars[3] = CHAR_PAD;
         end else begin
            g            = {group_bits_ff[7:0], in_byte, 8'h00};
            job.chars[0] = sextet_char(g[23:18], cfg.url_alphabet);
            job.chars[1] = sextet_char(g[17:12], cfg.url_alphabet);
            job.chars[2] = sextet_char(g[11:6], cfg.url_alphabet);
            job.chars[3] = CHAR_PAD;
         end
         push = accept && last_byte;
      end
      // end of message: back to a clean state
      if (last_byte) begin
         group_bits_in  = '0;
         group_count_in = 2'd0;
         line_cnt_in    = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_bits_ff  <= '0;
         group_count_ff <= 2'd0;
         line_cnt_ff    <= 6'd0;
      end else if (accept) begin
         group_bits_ff  <= group_bits_in;
         group_count_ff <= group_count_in;
         line_cnt_ff    <= line_cnt_in;
      end
   end

endmodule

>>> rtl/b64_queue.sv
// Small job FIFO decoupling the front end from the character serializer.
module b64_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64_pkg::job_type      push_job,
   input  logic                  pop,
   output b64_pkg::job_type      pop_job,
   output b64_pkg::q_status_type status
);
   import b64_pkg::*;

   job_type         mem [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign status.full  = count_ff == (Q_AW+1)'(Q_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_job      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/b64_back.sv
// Back end: serializes each job into characters, one beat per cycle while rsp_stall is low.
module b64_back (
   input  logic                  clock,
   input  logic                  reset,
   input  b64_pkg::job_type      q_job,
   input  b64_pkg::q_status_type q_status,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last_char
);
   import b64_pkg::*;

   job_type    job_ff;
   logic [2:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       take, is_final;
   logic [2:0] final_idx;

   assign final_idx = job_ff.newline ? 3'd4 : 3'd3;
   assign is_final  = idx_ff == final_idx;
   assign rsp_valid = busy_ff;

   assign rsp_out_char  = (idx_ff == 3'd4) ? CHAR_NEWLINE : job_ff.chars[idx_ff[1:0]];
   assign rsp_last_char = job_ff.last && is_final;

   // free slot: idle, or the final beat of the current job leaves now
   assign take  = !busy_ff || (!rsp_stall && is_final);
   assign q_pop = take && !q_status.empty;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (take) begin
         busy_in = !q_status.empty;
         idx_in  = 3'd0;
      end else if (!rsp_stall) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

>>> rtl/base64_stream_encoder.sv
// Top level of the streaming Base64 encoder: config registers and front/queue/back.
//
// Input channel (req_*): one raw byte per beat, req_last_byte on the final
// byte of a message. Output channel (rsp_*): one ASCII character per beat,
// rsp_last_char on the final character of the encoded message.
// Every third byte releases four characters (plus a newline at line end when
// line breaks are on); a last byte closing a partial group releases the
// two or three characters padded with '=' to four.
// Config port (csr_*): index 0 selects the URL-safe alphabet, index 1
// enables a newline after every LINE_BYTES input bytes. Other indexes are
// dropped. csr_ready is always high; write only while the block is idle.
// The job for a group is written into the queue as the byte that completes
// it is accepted; the back end then registers it and presents its first character.
// Throughput: the back end emits one character per cycle while rsp_stall is
// low; the front takes one byte per cycle until the four-entry job queue fills.
// Reset (synchronous) clears the group state, queue and config registers.
// When the receiver stalls, characters hold and the front keeps taking
// bytes until the queue is full, then raises req_stall.
module base64_stream_encoder #(
   parameter int LINE_BYTES = 48
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic       csr_wdata
);
   import b64_pkg::*;

   cfg_type      cfg_ff;
   logic         req_accept;
   logic         push;
   job_type      push_job, q_job;
   logic         q_pop;
   q_status_type q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_URL_ALPHABET: cfg_ff.url_alphabet       <= csr_wdata;
            CSR_LINE_BREAKS:  cfg_ff.insert_line_breaks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stall only on a full queue; this never depends on req_valid
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   b64_front #(
      .LINE_BYTES (LINE_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (req_accept),
      .in_byte   (req_in_byte),
      .last_byte (req_last_byte),
      .push      (push),
      .job       (push_job)
   );

   b64_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (q_job),
      .status   (q_status)
   );

   b64_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_job         (q_job),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

>>> verif/b64_checker.sv
// Channel monitor with Base64 character prediction and beat-by-beat compare.
`timescale 1ns / 100ps

module b64_stream_checker #(
   parameter int LINE_BYTES = 48
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_char,
   input  logic       rsp_last_char,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic       csr_wdata,
   output int         mismatches,
   output int         chars_pending
);
   import b64_pkg::*;

   typedef struct packed {
      logic [7:0] code;
      logic       closes;
   } encoded_char_type;

   encoded_char_type expected_chars[$];

   // Shadow of the encoder state and its two registers
   logic [15:0] held_bits;
   logic [1:0]  held_count;
   logic [5:0]  line_count;
   logic        url_sel;
   logic        breaks_on;
   int          error_total;

   initial begin
      error_total = 0;
   end

   function automatic logic [7:0] sextet_ascii(input logic [5:0] v, input logic url);
      if (v < 6'd26) return 8'h41 + 8'(v);            // A..Z
      if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);    // a..z
      if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);    // 0..9
      if (v == 6'd62) return url ? 8'h2D : 8'h2B;     // - or +
      return url ? 8'h5F : 8'h2F;                     // _ or /
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic fin);
      logic [23:0]      grp;
      logic [6:0]       cnt;
      logic [7:0]       chars[0:4];
      int               n;
      int               k;
      encoded_char_type beat;
      n = 0;
      if (held_count == 2'd2) begin
         grp = {held_bits, b};
         chars[0] = sextet_ascii(grp[23:18], url_sel);
         chars[1] = sextet_ascii(grp[17:12], url_sel);
         chars[2] = sextet_ascii(grp[11:6], url_sel);
         chars[3] = sextet_ascii(grp[5:0], url_sel);
         n = 4;
         held_bits  = '0;
         held_count = '0;
         // count moves in whole groups; a line ends once it reaches the limit
         cnt = {1'b0, line_count} + 7'd3;
         if (cnt >= LINE_BYTES) begin
            if (breaks_on) begin
               chars[4] = CHAR_NEWLINE;
               n = 5;
            end
            cnt = '0;
         end
         line_count = cnt[5:0];
      end else begin
         held_bits  = {held_bits[7:0], b};
         held_count = held_count + 2'd1;
         if (fin) begin
            grp = (held_count == 2'd1) ? {held_bits[7:0], 16'h0} : {held_bits, 8'h0};
            chars[0] = sextet_ascii(grp[23:18], url_sel);
            chars[1] = sextet_ascii(grp[17:12], url_sel);
            chars[2] = (held_count == 2'd1) ? CHAR_PAD : sextet_ascii(grp[11:6], url_sel);
            chars[3] = CHAR_PAD;
            n = 4;
         end
      end
      if (fin) begin
         held_bits  = '0;
         held_count = '0;
         line_count = '0;
      end
      for (k = 0; k < n; k++) begin
         beat.code   = chars[k];
         beat.closes = fin && (k == n - 1);
         expected_chars.push_back(beat);
      end
   endtask

   task automatic report(input string what, input logic [7:0] exp_v, input logic [7:0] got_v);
      error_total++;
      $display("%0t: %s expected %h actual %h", $time, what, exp_v, got_v);
   endtask

   always @(posedge clock) begin
      encoded_char_type want;
      if (reset) begin
         expected_chars.delete();
         held_bits  = '0;
         held_count = '0;
         line_count = '0;
         url_sel    = 1'b0;
         breaks_on  = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               report("unexpected beat, out_char", 8'h00, rsp_out_char);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.code)
                  report("out_char", want.code, rsp_out_char);
               if (rsp_last_char !== want.closes)
                  report("last_char", 8'(want.closes), 8'(rsp_last_char));
            end
         end
         if (req_valid && !req_stall)
            predict_byte(req_in_byte, req_last_byte);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_URL_ALPHABET: url_sel   = csr_wdata;
               CSR_LINE_BREAKS:  breaks_on = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatches    <= error_total;
      chars_pending <= expected_chars.size();
   end

endmodule

>>> verif/testbench.sv
// Top of the Base64 encoder bench: clock, reset, byte stimulus, config writes and verdict.
`timescale 1ns / 100ps

module testbench;
   import b64_pkg::*;

   localparam int LINE_BYTES = 48;

   // Indexes past the two real registers; the block must drop these writes
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   localparam int IDLE_PCT      = 13;    // chance of a gap / stall per beat
   localparam int QUIET_CYCLES  = 10;    // settle time after the last character
   localparam int HOLD_START    = 400;   // receiver hold-off window, in cycles
   localparam int HOLD_CYCLES   = 150;
   localparam int CLEAN_CYCLES  = 350;   // stall-free stretch right after it
   localparam int PHASE_BYTES   = 70;
   localparam int WATCHDOG_MAX  = 1000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = '0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_char;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic       csr_wdata = 1'b0;

   int mismatches;
   int chars_pending;
   int bytes_sent = 0;
   int stall_free_cycles;
   bit sender_no_gaps = 1'b0;

   always #2 clock = ~clock;

   base64_stream_encoder #(.LINE_BYTES(LINE_BYTES)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   b64_stream_checker #(.LINE_BYTES(LINE_BYTES)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .chars_pending (chars_pending)
   );

   // One input beat. An optional gap comes first, with valid low;
   // after that valid stays up and the payload holds until the beat is taken.
   // Every signal gets a single NBA per time step: the gap drops valid once, the
   // offer raises it once, and the caller's next call or drain_encoder follows.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (!sender_no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_message(input int len);
      int i;
      for (i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   // Quiesce: valid drops, every predicted character has to come out, then a
   // settle stretch covers a first or second byte of a group still in flight.
   task automatic drain_encoder();
      req_valid <= 1'b0;
      do @(posedge clock); while (chars_pending != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // csr_ready is always high in this block, but the handshake is honored anyway.
   // Valid drops for one cycle after each write so back-to-back writes stay clean.
   task automatic write_csr(input logic [1:0] idx, input logic val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One configuration setting followed by a burst of random traffic. Mostly
   // complete messages of varied length: short ones exercise the padding,
   // long ones cross the line boundary, exact multiples of the line length end
   // on a newline if breaks are on. The rest: short runs, last flag at random.
   task automatic run_phase(input logic url, input logic breaks);
      int stop_at;
      int pick;
      drain_encoder();
      write_csr(CSR_URL_ALPHABET, url);
      write_csr(CSR_LINE_BREAKS, breaks);
      write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, 1'($urandom_range(0, 1)));
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            send_message($urandom_range(1, 20));
         else if (pick < 65)
            send_message($urandom_range(40, 100));
         else if (pick < 80)
            send_message($urandom_range(1, 2) * LINE_BYTES);
         else
            repeat ($urandom_range(1, 8))
               send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Receiver: random stalls, except one long hold-off that backs the encoder
   // up until req_stall rises, followed by a stretch that takes every beat.
   initial begin
      stall_free_cycles = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         stall_free_cycles++;
         if (stall_free_cycles >= HOLD_START && stall_free_cycles < HOLD_START + HOLD_CYCLES)
            rsp_stall <= 1'b1;
         else if (stall_free_cycles >= HOLD_START + HOLD_CYCLES &&
                  stall_free_cycles < HOLD_START + HOLD_CYCLES + CLEAN_CYCLES)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Watchdog: no beat on any channel for too long means the block is hung.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_MAX) begin
            $display("%0t: no beat for %0d cycles, %0d characters still due",
                     $time, quiet, chars_pending);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset configuration: standard alphabet, no newlines.
      send_byte(8'h00, 1'b1);                  // one byte, two pads
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);                  // two bytes, one pad
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFB, 1'b0);                  // sextets 62,63,62,63: + and /
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'h00, 1'b0);                  // full group, then a partial tail
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);                  // plain text group
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);

      // URL-safe alphabet on the same high sextets, then a one-byte tail
      drain_encoder();
      write_csr(CSR_URL_ALPHABET, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hFE, 1'b1);

      // Random part across all four settings; the second phase runs gap-free.
      run_phase(1'b1, 1'b1);
      sender_no_gaps = 1'b1;
      run_phase(1'b0, 1'b1);
      sender_no_gaps = 1'b0;
      run_phase(1'b0, 1'b0);
      run_phase(1'b1, 1'b0);

      drain_encoder();
      if (mismatches == 0 && chars_pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
rtl/b64_pkg.sv
rtl/b64_front.sv
rtl/b64_queue.sv
rtl/b64_back.sv
rtl/base64_stream_encoder.sv
verif/b64_checker.sv
verif/testbench.sv
